@@ design/coap_option_parser_defines.svh @@
// Assertion macros shared by the parser RTL.
`ifndef COAP_OPTION_PARSER_DEFINES_SVH
`define COAP_OPTION_PARSER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define COAP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define COAP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/coap_pkg.sv @@
// Shared types and constants of the CoAP option parser.
package coap_pkg;

	localparam int MAX_MESSAGE_BYTES = 256;

	localparam logic [7:0] PAYLOAD_MARKER = 8'hFF;
	localparam logic [7:0] END_OF_OPTIONS = 8'h00;

	localparam logic [3:0] NIB_EXT1 = 4'd13;
	localparam logic [3:0] NIB_EXT2 = 4'd14;
	localparam logic [3:0] NIB_RSVD = 4'd15;

	localparam logic [16:0] EXT1_BASE = 17'd13;
	localparam logic [16:0] EXT2_BASE = 17'd269;

	localparam logic [16:0] OPT_URI_PATH = 17'd11;
	localparam logic [16:0] OPT_BLOCK2 = 17'd23;
	localparam logic [16:0] OPT_BLOCK1 = 17'd27;

	localparam logic [1:0] BLOCK_NONE = 2'd0;
	localparam logic [1:0] BLOCK_ONE = 2'd1;
	localparam logic [1:0] BLOCK_TWO = 2'd2;

	typedef struct packed {
		logic valid;
		logic [7:0] byte_value;
		logic last_byte;
	} coap_item_t;

	typedef struct packed {
		logic [7:0] method_code;
		logic [3:0] token_length;
		logic [7:0] uri_offset;
		logic [8:0] uri_length;
		logic [1:0] block_kind;
		logic [7:0] block_byte;
		logic [8:0] payload_offset;
		logic malformed;
	} coap_result_t;

endpackage

@@ design/coap_in_stage.sv @@
// Input register stage of the CoAP option parser.
module coap_in_stage (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] byte_value,
	input  logic last_byte,
	input  logic take,
	output coap_pkg::coap_item_t item_s1
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;

	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= byte_value;
			last_s1 <= last_byte;
		end
	end

	assign item_s1.valid = valid_s1;
	assign item_s1.byte_value = byte_s1;
	assign item_s1.last_byte = last_s1;

endmodule

@@ design/coap_parse_core.sv @@
// Per-byte parse state and next-state logic of the CoAP option parser.
`include "coap_option_parser_defines.svh"

module coap_parse_core (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  coap_pkg::coap_item_t item_s1,
	output logic res_valid,
	output coap_pkg::coap_result_t res
);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_DESC,
		PH_DELTA_EXT,
		PH_LEN_EXT,
		PH_VALUE,
		PH_IDLE
	} phase_t;

	phase_t phase_q, phase_n;
	logic [8:0] pos_q, pos_n;
	logic [16:0] rem_q, rem_n;
	logic [16:0] optnum_q, optnum_n;
	logic [3:0] dnib_q, dnib_n;
	logic [3:0] lnib_q, lnib_n;
	logic [7:0] ext_hi_q, ext_hi_n;
	logic is_uri_q, is_uri_n;
	logic is_block_q, is_block_n;
	logic cap_q, cap_n;
	logic [7:0] method_q, method_n;
	logic [3:0] tok_q, tok_n;
	logic [7:0] uri_off_q, uri_off_n;
	logic [8:0] uri_len_q, uri_len_n;
	logic [1:0] bkind_q, bkind_n;
	logic [7:0] bbyte_q, bbyte_n;
	logic [8:0] pay_q, pay_n;
	logic malf_q, malf_n;

	logic [7:0] b;
	logic do_resolve, do_after, do_start;
	logic [16:0] delta, len;
	logic [17:0] sum;
	logic [16:0] rem_dec;

	assign b = item_s1.byte_value;
	assign rem_dec = (rem_q != '0) ? (rem_q - 17'd1) : rem_q;

	always_comb begin
		phase_n = phase_q;
		pos_n = pos_q;
		rem_n = rem_q;
		optnum_n = optnum_q;
		dnib_n = dnib_q;
		lnib_n = lnib_q;
		ext_hi_n = ext_hi_q;
		is_uri_n = is_uri_q;
		is_block_n = is_block_q;
		cap_n = cap_q;
		method_n = method_q;
		tok_n = tok_q;
		uri_off_n = uri_off_q;
		uri_len_n = uri_len_q;
		bkind_n = bkind_q;
		bbyte_n = bbyte_q;
		pay_n = pay_q;
		malf_n = malf_q;
		do_resolve = 1'b0;
		do_after = 1'b0;
		do_start = 1'b0;
		delta = '0;
		len = '0;
		sum = '0;
		res_valid = 1'b0;

		if (32'(pos_q) >= 32'(coap_pkg::MAX_MESSAGE_BYTES)) begin
			malf_n = 1'b1;
		end else begin
			case (phase_q)
				PH_HEADER: begin
					if (pos_q == 9'd0) begin
						tok_n = b[3:0];
					end else if (pos_q == 9'd1) begin
						method_n = b;
					end
					if (pos_q >= 9'd3) begin
						phase_n = (tok_n == 4'd0) ? PH_DESC : PH_TOKEN;
					end
					rem_n = 17'(tok_n);
				end
				PH_TOKEN: begin
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						phase_n = PH_DESC;
					end
				end
				PH_DESC: begin
					if (b == coap_pkg::PAYLOAD_MARKER) begin
						pay_n = pos_q + 9'd1;
						phase_n = PH_IDLE;
					end else if (b == coap_pkg::END_OF_OPTIONS) begin
						phase_n = PH_IDLE;
					end else begin
						dnib_n = b[7:4];
						lnib_n = b[3:0];
						if (b[7:4] == coap_pkg::NIB_RSVD || b[3:0] == coap_pkg::NIB_RSVD) begin
							malf_n = 1'b1;
							phase_n = PH_IDLE;
						end else if (b[7:4] >= coap_pkg::NIB_EXT1) begin
							rem_n = (b[7:4] == coap_pkg::NIB_EXT1) ? 17'd1 : 17'd2;
							phase_n = PH_DELTA_EXT;
						end else begin
							do_resolve = 1'b1;
							delta = 17'(b[7:4]);
							do_after = 1'b1;
						end
					end
				end
				PH_DELTA_EXT: begin
					if (dnib_q == coap_pkg::NIB_EXT2 && rem_q == 17'd2) begin
						ext_hi_n = b;
						rem_n = 17'd1;
					end else begin
						do_resolve = 1'b1;
						delta = (dnib_q == coap_pkg::NIB_EXT1) ?
							(coap_pkg::EXT1_BASE + 17'(b)) :
							(coap_pkg::EXT2_BASE + {1'b0, ext_hi_q, b});
						do_after = 1'b1;
					end
				end
				PH_LEN_EXT: begin
					if (lnib_q == coap_pkg::NIB_EXT2 && rem_q == 17'd2) begin
						ext_hi_n = b;
						rem_n = 17'd1;
					end else begin
						do_start = 1'b1;
						len = (lnib_q == coap_pkg::NIB_EXT1) ?
							(coap_pkg::EXT1_BASE + 17'(b)) :
							(coap_pkg::EXT2_BASE + {1'b0, ext_hi_q, b});
					end
				end
				PH_VALUE: begin
					if (cap_q) begin
						bbyte_n = b;
						cap_n = 1'b0;
					end
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						phase_n = PH_DESC;
					end
				end
				default: begin
				end
			endcase

			if (do_resolve) begin
				sum = {1'b0, optnum_q} + {1'b0, delta};
				optnum_n = sum[17] ? '1 : sum[16:0];
				is_uri_n = (optnum_n == coap_pkg::OPT_URI_PATH);
				is_block_n = (optnum_n == coap_pkg::OPT_BLOCK2) ||
					(optnum_n == coap_pkg::OPT_BLOCK1);
				if (optnum_n == coap_pkg::OPT_BLOCK2) begin
					bkind_n = coap_pkg::BLOCK_TWO;
				end
				if (optnum_n == coap_pkg::OPT_BLOCK1) begin
					bkind_n = coap_pkg::BLOCK_ONE;
				end
			end

			if (do_after) begin
				if (lnib_n < coap_pkg::NIB_EXT1) begin
					do_start = 1'b1;
					len = 17'(lnib_n);
				end else begin
					rem_n = (lnib_n == coap_pkg::NIB_EXT1) ? 17'd1 : 17'd2;
					phase_n = PH_LEN_EXT;
				end
			end

			if (do_start) begin
				if (is_uri_n) begin
					uri_off_n = pos_q[7:0] + 8'd1;
					uri_len_n = (len > 17'd511) ? 9'd511 : len[8:0];
				end
				cap_n = 1'b0;
				if (is_block_n) begin
					bbyte_n = '0;
					cap_n = len[0];
				end
				if (len == '0) begin
					phase_n = PH_DESC;
				end else begin
					rem_n = len;
					phase_n = PH_VALUE;
				end
			end
		end

		pos_n = (pos_q != 9'd511) ? (pos_q + 9'd1) : pos_q;

		if (item_s1.last_byte) begin
			if (phase_n == PH_DELTA_EXT || phase_n == PH_LEN_EXT || phase_n == PH_VALUE) begin
				malf_n = 1'b1;
			end
			res_valid = fire;
		end

		res.method_code = method_n;
		res.token_length = tok_n;
		res.uri_offset = uri_off_n;
		res.uri_length = uri_len_n;
		res.block_kind = bkind_n;
		res.block_byte = bbyte_n;
		res.payload_offset = pay_n;
		res.malformed = malf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			rem_q <= '0;
			optnum_q <= '0;
			dnib_q <= '0;
			lnib_q <= '0;
			ext_hi_q <= '0;
			is_uri_q <= 1'b0;
			is_block_q <= 1'b0;
			cap_q <= 1'b0;
			method_q <= '0;
			tok_q <= '0;
			uri_off_q <= '0;
			uri_len_q <= '0;
			bkind_q <= coap_pkg::BLOCK_NONE;
			bbyte_q <= '0;
			pay_q <= '0;
			malf_q <= 1'b0;
		end else if (fire) begin
			if (item_s1.last_byte) begin
				phase_q <= PH_HEADER;
				pos_q <= '0;
				rem_q <= '0;
				optnum_q <= '0;
				dnib_q <= '0;
				lnib_q <= '0;
				ext_hi_q <= '0;
				is_uri_q <= 1'b0;
				is_block_q <= 1'b0;
				cap_q <= 1'b0;
				method_q <= '0;
				tok_q <= '0;
				uri_off_q <= '0;
				uri_len_q <= '0;
				bkind_q <= coap_pkg::BLOCK_NONE;
				bbyte_q <= '0;
				pay_q <= '0;
				malf_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				pos_q <= pos_n;
				rem_q <= rem_n;
				optnum_q <= optnum_n;
				dnib_q <= dnib_n;
				lnib_q <= lnib_n;
				ext_hi_q <= ext_hi_n;
				is_uri_q <= is_uri_n;
				is_block_q <= is_block_n;
				cap_q <= cap_n;
				method_q <= method_n;
				tok_q <= tok_n;
				uri_off_q <= uri_off_n;
				uri_len_q <= uri_len_n;
				bkind_q <= bkind_n;
				bbyte_q <= bbyte_n;
				pay_q <= pay_n;
				malf_q <= malf_n;
			end
		end
	end

	`COAP_ASSERT_NXT(a_restart_after_result, res_valid, pos_q == 9'd0 && phase_q == PH_HEADER, "parser did not restart after a result")
	`COAP_ASSERT_IMP(a_value_has_bytes, phase_q == PH_VALUE, rem_q != '0, "value phase with no bytes left")
	`COAP_ASSERT_NXT(a_idle_holds, fire && !item_s1.last_byte && phase_q == PH_IDLE, phase_q == PH_IDLE, "left idle phase before message end")
	`COAP_ASSERT_IMP(a_result_only_on_last, res_valid, fire && item_s1.last_byte, "result without a final byte")
	`COAP_ASSERT_IMP(a_block_kind_legal, res_valid, res.block_kind != 2'd3, "illegal block kind")

endmodule

@@ design/coap_option_parser.sv @@
// CoAP option parser top level: input register, parse core and result register.
// Streams one CoAP message byte per item and returns one result item on the
// byte marked last_byte: method code, token length, offset and length of the
// last Uri-Path option, kind and first value byte of the last Block option
// (zero for an even length), payload offset and a malformed flag. One byte
// is taken every cycle unless the input stalls. A final byte held in the
// input register feeds the combinational parse update; its result is loaded
// into the output register when the parse core takes that byte. Input stalls
// only when a final byte waits on a result that is still not taken. After
// each result the parser is back at its reset state for the next message.
module coap_option_parser (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] byte_value,
	input  logic last_byte,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] method_code,
	output logic [3:0] token_length,
	output logic [7:0] uri_offset,
	output logic [8:0] uri_length,
	output logic [1:0] block_kind,
	output logic [7:0] block_byte,
	output logic [8:0] payload_offset,
	output logic malformed
);

	coap_pkg::coap_item_t item_s1;
	coap_pkg::coap_result_t res;
	coap_pkg::coap_result_t res_q;
	logic res_valid;
	logic take;
	logic out_valid_q;

	assign take = item_s1.valid && (!item_s1.last_byte || !out_valid_q || !out_stall);

	coap_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.take(take),
		.item_s1(item_s1)
	);

	coap_parse_core u_parse_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(take),
		.item_s1(item_s1),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign method_code = res_q.method_code;
	assign token_length = res_q.token_length;
	assign uri_offset = res_q.uri_offset;
	assign uri_length = res_q.uri_length;
	assign block_kind = res_q.block_kind;
	assign block_byte = res_q.block_byte;
	assign payload_offset = res_q.payload_offset;
	assign malformed = res_q.malformed;

endmodule
